@@ rtl/smm_pkg.sv @@
// Shared types, constants and helpers for the small matrix multiply block.
package smm_pkg;

    // Fixed field widths
    localparam int CFG_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int ELEM_BITS  = 16;
    localparam int PROD_W     = 35;
    localparam int POS_W      = 3;
    // Store address field in the command queue; covers stores of up to 16 x 16
    localparam int ADDR_MAX_W = 8;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 2'd2;

    // Input kind codes
    localparam logic KIND_A = 1'b0;
    localparam logic KIND_B = 1'b1;

    typedef struct packed {
        logic                        kind;
        logic signed [ELEM_BITS-1:0] element;
    } smm_item_t;

    typedef struct packed {
        logic signed [PROD_W-1:0] product;
        logic [POS_W-1:0]         out_row;
        logic [POS_W-1:0]         out_col;
        logic                     last;
    } smm_result_t;

    typedef struct packed {
        logic [CFG_W-1:0] rows_a;
        logic [CFG_W-1:0] inner_len;
        logic [CFG_W-1:0] cols_b;
    } smm_cfg_t;

    localparam smm_cfg_t CFG_RESET = '{rows_a: 4'd1, inner_len: 4'd1, cols_b: 4'd1};

    // Classified item passed from the front end to the compute side
    typedef struct packed {
        logic                        is_b;
        logic                        fire;     // last element of B: run the product
        logic [ADDR_MAX_W-1:0]       addr;
        logic signed [ELEM_BITS-1:0] element;
    } smm_cmd_t;

    // Dimension actually used: zero reads as one, large values clamp to max_dim
    function automatic logic [CFG_W:0] eff_dim(input logic [CFG_W-1:0] v, input int max_dim);
        logic [CFG_W:0] r;
        if (v == '0)
            r = (CFG_W+1)'(1);
        else if (int'(v) > max_dim)
            r = (CFG_W+1)'(max_dim);
        else
            r = {1'b0, v};
        return r;
    endfunction

endpackage

@@ rtl/smm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module smm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/smm_front.sv @@
// Front end: accepts items, tracks load counts and classifies each item.
module smm_front #(
    parameter int MAX_DIM = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  smm_pkg::smm_cfg_t   cfg,
    input  logic                item_valid,
    output logic                item_ready,
    input  smm_pkg::smm_item_t  item,
    input  logic                q_full,
    output logic                push,
    output smm_pkg::smm_cmd_t   cmd
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int DIM_W = $clog2(MAX_DIM + 1);

    logic [DIM_W-1:0]   dim_r, dim_n, dim_c;
    logic [2*DIM_W-1:0] size_a_full, size_b_full;
    logic [CNT_W-1:0]   size_a, size_b;
    logic [CNT_W-1:0]   cnt_a_reg, cnt_a_next, cnt_b_reg, cnt_b_next, cnt_b_inc;
    logic               accept;

    // Matrix sizes from the clamped dimensions
    assign dim_r       = DIM_W'(smm_pkg::eff_dim(cfg.rows_a, MAX_DIM));
    assign dim_n       = DIM_W'(smm_pkg::eff_dim(cfg.inner_len, MAX_DIM));
    assign dim_c       = DIM_W'(smm_pkg::eff_dim(cfg.cols_b, MAX_DIM));
    assign size_a_full = dim_r * dim_n;
    assign size_b_full = dim_n * dim_c;
    assign size_a      = CNT_W'(size_a_full);
    assign size_b      = CNT_W'(size_b_full);

    assign item_ready = !q_full;
    assign accept     = item_valid && item_ready;

    // Classify: store into A, store into B, store last B and fire, or drop
    always_comb
    begin
        cnt_a_next  = cnt_a_reg;
        cnt_b_next  = cnt_b_reg;
        cnt_b_inc   = cnt_b_reg + CNT_W'(1);
        push        = 1'b0;
        cmd.is_b    = item.kind;
        cmd.fire    = 1'b0;
        cmd.addr    = smm_pkg::ADDR_MAX_W'(cnt_a_reg);
        cmd.element = item.element;
        if (accept)
        begin
            if (item.kind == smm_pkg::KIND_A)
            begin
                if (cnt_a_reg < size_a)
                begin
                    push       = 1'b1;
                    cnt_a_next = cnt_a_reg + CNT_W'(1);
                end
            end
            else if (cnt_b_reg < size_b)
            begin
                push     = 1'b1;
                cmd.addr = smm_pkg::ADDR_MAX_W'(cnt_b_reg);
                if (cnt_b_inc == size_b)
                begin
                    cmd.fire   = 1'b1;
                    cnt_a_next = '0;
                    cnt_b_next = '0;
                end
                else
                begin
                    cnt_b_next = cnt_b_inc;
                end
            end
        end
    end

    // Load counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_a_reg <= '0;
            cnt_b_reg <= '0;
        end
        else
        begin
            cnt_a_reg <= cnt_a_next;
            cnt_b_reg <= cnt_b_next;
        end
    end

endmodule

@@ rtl/smm_queue.sv @@
// Two-entry command queue between the front end and the compute side.
module smm_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  smm_pkg::smm_cmd_t push_cmd,
    output logic              full,
    input  logic              pop,
    output logic              q_valid,
    output smm_pkg::smm_cmd_t q_cmd
);

    localparam int QDEPTH = 2;
    localparam int PTR_W  = $clog2(QDEPTH);
    localparam int CNT_W  = $clog2(QDEPTH + 1);

    smm_pkg::smm_cmd_t slot_reg [QDEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign full    = (count_reg == CNT_W'(QDEPTH));
    assign q_valid = (count_reg != '0);
    assign q_cmd   = slot_reg[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + CNT_W'(1);
                2'b01:   count_reg <= count_reg - CNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("item pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("queue popped while empty");
`endif

endmodule

@@ rtl/smm_back.sv @@
// Compute side: writes the stores, walks the multiply-accumulate, holds the result.
module smm_back #(
    parameter int MAX_DIM = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  smm_pkg::smm_cfg_t    cfg,
    input  logic                 q_valid,
    input  smm_pkg::smm_cmd_t    q_cmd,
    output logic                 pop,
    output logic                 result_valid,
    input  logic                 result_ready,
    output smm_pkg::smm_result_t result
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int IDX_W = $clog2(MAX_DIM);
    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int EW    = smm_pkg::ELEM_BITS;

    typedef enum logic [1:0] {S_IDLE, S_CALC, S_DRAIN, S_EMIT} state_t;

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [AW-1:0]        row_base_reg, row_base_next;
    logic [AW-1:0]        addr_a_reg, addr_a_next, addr_b_reg, addr_b_next;
    logic                 result_valid_reg, result_valid_next;
    smm_pkg::smm_result_t result_reg, result_next;

    logic [DIM_W-1:0]     dim_r, dim_n, dim_c;
    logic                 k_last, row_last, col_last, issue;
    logic                 we_a, we_b;
    logic [EW-1:0]        rdata_a, rdata_b;

    logic                 v1_reg, first1_reg, v2_reg, first2_reg;
    logic signed [2*EW-1:0]            prod_reg;
    logic signed [smm_pkg::PROD_W-1:0] prod_ext, acc_reg;

    assign dim_r = DIM_W'(smm_pkg::eff_dim(cfg.rows_a, MAX_DIM));
    assign dim_n = DIM_W'(smm_pkg::eff_dim(cfg.inner_len, MAX_DIM));
    assign dim_c = DIM_W'(smm_pkg::eff_dim(cfg.cols_b, MAX_DIM));

    assign k_last   = (DIM_W'(k_reg) == dim_n - DIM_W'(1));
    assign row_last = (DIM_W'(i_reg) == dim_r - DIM_W'(1));
    assign col_last = (DIM_W'(j_reg) == dim_c - DIM_W'(1));

    // Element stores
    assign we_a = pop && !q_cmd.is_b;
    assign we_b = pop && q_cmd.is_b;

    smm_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_store_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (q_cmd.addr[AW-1:0]),
        .wdata (q_cmd.element),
        .raddr (addr_a_reg),
        .rdata (rdata_a)
    );

    smm_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_store_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (q_cmd.addr[AW-1:0]),
        .wdata (q_cmd.element),
        .raddr (addr_b_reg),
        .rdata (rdata_b)
    );

    // Sequencer next state
    always_comb
    begin
        state_next        = state_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        k_next            = k_reg;
        row_base_next     = row_base_reg;
        addr_a_next       = addr_a_reg;
        addr_b_next       = addr_b_reg;
        result_valid_next = result_valid_reg && !result_ready;
        result_next       = result_reg;
        pop               = 1'b0;
        issue             = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    pop = 1'b1;
                    if (q_cmd.fire)
                    begin
                        state_next    = S_CALC;
                        i_next        = '0;
                        j_next        = '0;
                        k_next        = '0;
                        row_base_next = '0;
                        addr_a_next   = '0;
                        addr_b_next   = '0;
                    end
                end
            end
            S_CALC:
            begin
                issue = 1'b1;
                if (k_last)
                begin
                    k_next     = '0;
                    state_next = S_DRAIN;
                end
                else
                begin
                    k_next      = k_reg + IDX_W'(1);
                    addr_a_next = addr_a_reg + AW'(1);
                    addr_b_next = addr_b_reg + AW'(dim_c);
                end
            end
            S_DRAIN:
            begin
                if (!v1_reg && !v2_reg)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_valid_next   = 1'b1;
                    result_next.product = acc_reg;
                    result_next.out_row = smm_pkg::POS_W'(i_reg);
                    result_next.out_col = smm_pkg::POS_W'(j_reg);
                    result_next.last    = row_last && col_last;
                    if (row_last && col_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (col_last)
                    begin
                        j_next        = '0;
                        i_next        = i_reg + IDX_W'(1);
                        row_base_next = row_base_reg + AW'(dim_n);
                        addr_a_next   = row_base_reg + AW'(dim_n);
                        addr_b_next   = '0;
                        state_next    = S_CALC;
                    end
                    else
                    begin
                        j_next      = j_reg + IDX_W'(1);
                        addr_a_next = row_base_reg;
                        addr_b_next = AW'(j_reg) + AW'(1);
                        state_next  = S_CALC;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            i_reg            <= '0;
            j_reg            <= '0;
            k_reg            <= '0;
            row_base_reg     <= '0;
            addr_a_reg       <= '0;
            addr_b_reg       <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            i_reg            <= i_next;
            j_reg            <= j_next;
            k_reg            <= k_next;
            row_base_reg     <= row_base_next;
            addr_a_reg       <= addr_a_next;
            addr_b_reg       <= addr_b_next;
            result_valid_reg <= result_valid_next;
            result_reg       <= result_next;
        end
    end

    // Multiply-accumulate pipeline: read, multiply, accumulate
    assign prod_ext = smm_pkg::PROD_W'(prod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        first1_reg <= (k_reg == '0);
        first2_reg <= first1_reg;
        prod_reg   <= $signed(rdata_a) * $signed(rdata_b);
        if (v2_reg)
        begin
            acc_reg <= first2_reg ? prod_ext : acc_reg + prod_ext;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef NO_ASSERTIONS
    a_emit_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (!v1_reg && !v2_reg))
        else $error("result taken while the accumulator pipeline is busy");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == S_EMIT))
        else $error("result raised outside the emit step");
`endif

endmodule

@@ rtl/small_matrix_multiply.sv @@
// Top level of the small matrix multiply block: configuration registers and wiring.
//
//  channel  direction  handshake                  payload
//  item     in         item_valid / item_ready    item   (kind, element)
//  result   out        result_valid / result_ready result (product, out_row, out_col, last)
//  cfg      in         cfg_we                     cfg_index, cfg_data
//
// Loading: one item per cycle while the queue has room; items pass through a two-entry queue into the stores.
// The item that completes B starts the product: each result element is formed by inner_len
// reads through the single multiply-accumulate unit, a drain of its pipeline and an emit step.
// Reset: registers read as 1, load counts clear; the stores are not cleared.
// Input stalls only when the queue is full; the queue does not drain during a product.
// A stalled result holds the sequencer in its emit step.
module small_matrix_multiply #(
    parameter int MAX_DIM = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [smm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [smm_pkg::CFG_W-1:0]        cfg_data,
    input  logic                             item_valid,
    output logic                             item_ready,
    input  smm_pkg::smm_item_t               item,
    output logic                             result_valid,
    input  logic                             result_ready,
    output smm_pkg::smm_result_t             result
);

    smm_pkg::smm_cfg_t cfg_reg;
    smm_pkg::smm_cmd_t push_cmd, q_cmd;
    logic              push, q_full, pop, q_valid;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= smm_pkg::CFG_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                smm_pkg::REG_ROWS_A:    cfg_reg.rows_a    <= cfg_data;
                smm_pkg::REG_INNER_LEN: cfg_reg.inner_len <= cfg_data;
                smm_pkg::REG_COLS_B:    cfg_reg.cols_b    <= cfg_data;
                default:                cfg_reg           <= cfg_reg;
            endcase
        end
    end

    smm_front #(.MAX_DIM(MAX_DIM)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .q_full     (q_full),
        .push       (push),
        .cmd        (push_cmd)
    );

    smm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    smm_back #(.MAX_DIM(MAX_DIM)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the small matrix multiply block.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIM_LIMIT     = 8;
    localparam int STORE_DEPTH   = DIM_LIMIT * DIM_LIMIT;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int ITEMS_PER_PHASE = 25;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [smm_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [smm_pkg::CFG_W-1:0]     cfg_data;
    logic                          item_valid;
    logic                          item_ready;
    smm_pkg::smm_item_t            item_bus;
    logic                          result_valid;
    logic                          result_ready = 1'b0;
    smm_pkg::smm_result_t          result_bus;

    // Shadow of the block: register values, both stores and load counters
    logic [smm_pkg::CFG_W-1:0]            shadow_rows;
    logic [smm_pkg::CFG_W-1:0]            shadow_inner;
    logic [smm_pkg::CFG_W-1:0]            shadow_cols;
    logic signed [smm_pkg::ELEM_BITS-1:0] mat_a [STORE_DEPTH];
    logic signed [smm_pkg::ELEM_BITS-1:0] mat_b [STORE_DEPTH];
    bit                                   written_a [STORE_DEPTH];
    int unsigned                          fill_a;
    int unsigned                          fill_b;
    smm_pkg::smm_result_t                 pending_products [$];

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned loaded_items;
    int unsigned products_done;
    int unsigned results_seen;
    int unsigned fail_count;
    int unsigned cycle_count;
    smm_pkg::smm_result_t want;

    small_matrix_multiply #(.MAX_DIM(DIM_LIMIT)) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item_bus),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result_bus)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result side back-pressure, changed on the falling edge
    always @(negedge clk)
    begin
        result_ready = (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each result against the oldest predicted product element
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            results_seen++;
            if (pending_products.size() == 0)
            begin
                $error("unexpected result: product %0d row %0d col %0d last %0d",
                       result_bus.product, result_bus.out_row, result_bus.out_col,
                       result_bus.last);
                fail_count++;
            end
            else
            begin
                want = pending_products.pop_front();
                if (result_bus.product !== want.product)
                begin
                    $error("product: expected %0d, got %0d", want.product, result_bus.product);
                    fail_count++;
                end
                if (result_bus.out_row !== want.out_row)
                begin
                    $error("out_row: expected %0d, got %0d", want.out_row, result_bus.out_row);
                    fail_count++;
                end
                if (result_bus.out_col !== want.out_col)
                begin
                    $error("out_col: expected %0d, got %0d", want.out_col, result_bus.out_col);
                    fail_count++;
                end
                if (result_bus.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, result_bus.last);
                    fail_count++;
                end
            end
        end
    end

    // Dimension in force: zero acts as one, anything past the limit as the limit
    function automatic int unsigned dim_used(logic [smm_pkg::CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > DIM_LIMIT)
            return DIM_LIMIT;
        return 32'(v);
    endfunction

    // True when every A entry the next product reads has been written since reset
    function automatic bit a_store_covers(int unsigned count);
        for (int i = 0; i < count; i++)
            if (!written_a[i])
                return 1'b0;
        return 1'b1;
    endfunction

    // Apply one accepted item to the shadow; queue the product when B completes.
    // Returns 1 when the element was stored, 0 when it was ignored.
    function automatic bit load_element(smm_pkg::smm_item_t it);
        int unsigned          r;
        int unsigned          n;
        int unsigned          c;
        longint               sum;
        smm_pkg::smm_result_t elem;

        r = dim_used(shadow_rows);
        n = dim_used(shadow_inner);
        c = dim_used(shadow_cols);
        if (it.kind == smm_pkg::KIND_A)
        begin
            if (fill_a >= r * n)
                return 1'b0;
            mat_a[fill_a % STORE_DEPTH]     = it.element;
            written_a[fill_a % STORE_DEPTH] = 1'b1;
            fill_a++;
            return 1'b1;
        end
        if (fill_b >= n * c)
            return 1'b0;
        mat_b[fill_b % STORE_DEPTH] = it.element;
        fill_b++;
        if (fill_b == n * c)
        begin
            for (int i = 0; i < r; i++)
            begin
                for (int j = 0; j < c; j++)
                begin
                    sum = 0;
                    for (int k = 0; k < n; k++)
                        sum += longint'(mat_a[(i * n + k) % STORE_DEPTH])
                             * longint'(mat_b[(k * c + j) % STORE_DEPTH]);
                    elem.product = sum[smm_pkg::PROD_W-1:0];
                    elem.out_row = smm_pkg::POS_W'(i);
                    elem.out_col = smm_pkg::POS_W'(j);
                    elem.last    = (i == r - 1) && (j == c - 1);
                    pending_products.push_back(elem);
                end
            end
            products_done++;
            fill_a = 0;
            fill_b = 0;
        end
        return 1'b1;
    endfunction

    // Present one item, with random idle cycles ahead of it, and wait for acceptance
    task automatic send_item(input logic kind, input logic [smm_pkg::ELEM_BITS-1:0] value);
        @(negedge clk);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            item_valid = 1'b0;
            @(negedge clk);
        end
        item_bus.kind    = kind;
        item_bus.element = value;
        item_valid       = 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        if (load_element(item_bus))
            loaded_items++;
    endtask

    // Drop valid, then wait until every predicted result has arrived and let the block settle
    task automatic wait_idle();
        @(negedge clk);
        item_valid = 1'b0;
        while (pending_products.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [smm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [smm_pkg::CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we    = 1'b0;
        case (idx)
            smm_pkg::REG_ROWS_A:    shadow_rows  = val;
            smm_pkg::REG_INNER_LEN: shadow_inner = val;
            smm_pkg::REG_COLS_B:    shadow_cols  = val;
            default:                ;
        endcase
    endtask

    task automatic write_dims(input logic [smm_pkg::CFG_W-1:0] r,
                              input logic [smm_pkg::CFG_W-1:0] n,
                              input logic [smm_pkg::CFG_W-1:0] c);
        write_reg(smm_pkg::REG_ROWS_A, r);
        write_reg(smm_pkg::REG_INNER_LEN, n);
        write_reg(smm_pkg::REG_COLS_B, c);
    endtask

    // Mostly small dimensions, now and then zero, a mid value or one that clamps
    function automatic logic [smm_pkg::CFG_W-1:0] pick_dim();
        case ($urandom_range(9))
            0:       return '0;
            1:       return smm_pkg::CFG_W'($urandom_range(15, 9));
            2:       return smm_pkg::CFG_W'($urandom_range(8, 4));
            default: return smm_pkg::CFG_W'($urandom_range(3, 1));
        endcase
    endfunction

    // 1x1x1: extreme values, an element for a full A, and B completing with A empty
    task automatic test_single_element();
        wait_idle();
        write_dims(4'd1, 4'd1, 4'd1);
        send_item(smm_pkg::KIND_A, 16'h8000);
        send_item(smm_pkg::KIND_A, 16'h7FFF);
        send_item(smm_pkg::KIND_B, 16'h8000);
        // A store still holds the last element, so B alone yields a product
        send_item(smm_pkg::KIND_B, 16'h7FFF);
        send_item(smm_pkg::KIND_A, 16'h7FFF);
        send_item(smm_pkg::KIND_B, 16'h0000);
    endtask

    // Zero and oversized register values: 1 x 8 x 1, largest possible sum
    task automatic test_clamped_dims();
        wait_idle();
        write_dims(4'd0, 4'd15, 4'd0);
        repeat (8) send_item(smm_pkg::KIND_A, 16'h8000);
        repeat (8) send_item(smm_pkg::KIND_B, 16'h8000);
    endtask

    // Inner length shrinks while A is part loaded: A counts as full at once
    task automatic test_config_mid_load();
        wait_idle();
        write_dims(4'd2, 4'd2, 4'd2);
        repeat (3) send_item(smm_pkg::KIND_A, smm_pkg::ELEM_BITS'($urandom));
        wait_idle();
        write_reg(smm_pkg::REG_INNER_LEN, 4'd1);
        send_item(smm_pkg::KIND_A, smm_pkg::ELEM_BITS'($urandom));
        repeat (2) send_item(smm_pkg::KIND_B, smm_pkg::ELEM_BITS'($urandom));
    endtask

    // One full product; a scrambled one mixes A and B elements at random
    task automatic run_product(input bit scrambled);
        int unsigned start_count;
        int unsigned size_a;
        int unsigned size_b;
        logic        kind;

        start_count = products_done;
        size_a = dim_used(shadow_rows) * dim_used(shadow_inner);
        size_b = dim_used(shadow_inner) * dim_used(shadow_cols);
        while (products_done == start_count)
        begin
            if (scrambled)
                kind = logic'($urandom_range(1));
            else
                kind = (fill_a < size_a) ? smm_pkg::KIND_A : smm_pkg::KIND_B;
            // the odd surplus A element, which the block must drop
            if (!scrambled && fill_a >= size_a && $urandom_range(19) == 0)
                send_item(smm_pkg::KIND_A, smm_pkg::ELEM_BITS'($urandom));
            // never let B finish while A would be read from unwritten entries
            if (kind == smm_pkg::KIND_B && fill_b + 1 == size_b && !a_store_covers(size_a))
                kind = smm_pkg::KIND_A;
            send_item(kind, smm_pkg::ELEM_BITS'($urandom));
        end
    endtask

    // Random products under each pacing mode
    task automatic test_random_traffic();
        int unsigned target;
        bit          first;

        for (int ph = 0; ph < 4; ph++)
        begin
            wait_idle();
            case (ph)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 53;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 53;
                end
                default:
                begin
                    send_idle_pct  = 15;
                    recv_stall_pct = 15;
                end
            endcase
            target = loaded_items + ITEMS_PER_PHASE;
            first  = 1'b1;
            while (loaded_items < target)
            begin
                wait_idle();
                if (first)
                    write_dims(4'd8, 4'd1, 4'd8);
                else
                    write_dims(pick_dim(), pick_dim(), pick_dim());
                first = 1'b0;
                run_product($urandom_range(4) == 0);
            end
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // Main sequence
    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = smm_pkg::REG_ROWS_A;
        cfg_data       = '0;
        item_valid     = 1'b0;
        item_bus       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        loaded_items   = 0;
        products_done  = 0;
        results_seen   = 0;
        fail_count     = 0;
        cycle_count    = 0;
        shadow_rows    = 4'd1;
        shadow_inner   = 4'd1;
        shadow_cols    = 4'd1;
        fill_a         = 0;
        fill_b         = 0;
        foreach (written_a[i])
            written_a[i] = 1'b0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_single_element();
        test_clamped_dims();
        test_config_mid_load();
        test_random_traffic();
        wait_idle();

        $display("tb: %0d elements stored, %0d products, %0d result items checked",
                 loaded_items, products_done, results_seen);
        $display("tb: dimensions 1 to 8 incl. zero and clamped values, four pacing modes");
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
